### hdl/pce_pkg.sv
package pce_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CRC_WIDTH      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLYNOMIAL     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_VALUE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REFLECT_INPUT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REFLECT_OUTPUT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FINAL_XOR      = 3'd5;

  // field widths
  localparam int unsigned WidthW = 6;
  localparam int unsigned WordW  = 32;

  // reset values (crc-32)
  localparam logic [WidthW-1:0] RST_CRC_WIDTH      = 6'd32;
  localparam logic [WordW-1:0]  RST_POLYNOMIAL     = 32'h04c1_1db7;
  localparam logic [WordW-1:0]  RST_INITIAL_VALUE  = 32'hffff_ffff;
  localparam logic              RST_REFLECT_INPUT  = 1'b1;
  localparam logic              RST_REFLECT_OUTPUT = 1'b1;
  localparam logic [WordW-1:0]  RST_FINAL_XOR      = 32'hffff_ffff;

  // live configuration handed from the register bank to the datapath
  typedef struct packed {
    logic [WidthW-1:0] crc_width;
    logic [WordW-1:0]  polynomial;
    logic [WordW-1:0]  initial_value;
    logic              reflect_input;
    logic              reflect_output;
    logic [WordW-1:0]  final_xor;
  } cfg_t;

endpackage

### hdl/pce_in_if.sv
interface pce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/pce_out_if.sv
interface pce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

### hdl/pce_cfg_if.sv
interface pce_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pce_pkg::CfgIdxW-1:0]   index;
  logic [pce_pkg::WordW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/pce_cfg_regs.sv
module pce_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  pce_cfg_if.sink         cfg_chan,
  output pce_pkg::cfg_t   cfg
);

  pce_pkg::cfg_t cfg_r;

  // writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  // register bank, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_width      <= pce_pkg::RST_CRC_WIDTH;
      cfg_r.polynomial     <= pce_pkg::RST_POLYNOMIAL;
      cfg_r.initial_value  <= pce_pkg::RST_INITIAL_VALUE;
      cfg_r.reflect_input  <= pce_pkg::RST_REFLECT_INPUT;
      cfg_r.reflect_output <= pce_pkg::RST_REFLECT_OUTPUT;
      cfg_r.final_xor      <= pce_pkg::RST_FINAL_XOR;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        pce_pkg::CFG_CRC_WIDTH:      cfg_r.crc_width <= cfg_chan.data[pce_pkg::WidthW-1:0];
        pce_pkg::CFG_POLYNOMIAL:     cfg_r.polynomial <= cfg_chan.data;
        pce_pkg::CFG_INITIAL_VALUE:  cfg_r.initial_value <= cfg_chan.data;
        pce_pkg::CFG_REFLECT_INPUT:  cfg_r.reflect_input <= cfg_chan.data[0];
        pce_pkg::CFG_REFLECT_OUTPUT: cfg_r.reflect_output <= cfg_chan.data[0];
        pce_pkg::CFG_FINAL_XOR:      cfg_r.final_xor <= cfg_chan.data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/pce_fold.sv
module pce_fold #(
  parameter int unsigned MAX_WIDTH = 32,
  parameter int unsigned REG_W     = 32
) (
  input  pce_pkg::cfg_t             cfg,
  input  logic                      in_message,
  input  logic [REG_W-1:0]          crc_in,
  input  logic [7:0]                data_byte,
  output logic [REG_W-1:0]          crc_nxt,
  output logic [pce_pkg::WordW-1:0] crc_value
);

  localparam logic [pce_pkg::WidthW:0]   MaxW  = (pce_pkg::WidthW + 1)'(MAX_WIDTH);
  localparam logic [pce_pkg::WidthW-1:0] RegWc = pce_pkg::WidthW'(REG_W);

  logic [pce_pkg::WidthW-1:0] w;
  logic                       ok;
  logic [REG_W:0]             mask_ext;
  logic [REG_W-1:0]           mask;
  logic [REG_W-1:0]           topsel;
  logic [REG_W-1:0]           poly;
  logic [REG_W-1:0]           crc;
  logic [REG_W-1:0]           rev;
  logic [REG_W-1:0]           fin;
  logic [7:0]                 bits;

  assign w = cfg.crc_width;

  // supported widths, also bounded by the build-time maximum
  assign ok = ((w >= 6'd4 && w <= 6'd8) || w == 6'd16 || w == 6'd24 || w == 6'd32) &&
              ({1'b0, w} <= MaxW);

  // width mask and top-bit selector
  assign mask_ext = ((REG_W + 1)'(1) << w) - (REG_W + 1)'(1);
  assign mask     = ok ? mask_ext[REG_W-1:0] : '0;
  assign topsel   = REG_W'(1) << (w - 6'd1);
  assign poly     = cfg.polynomial[REG_W-1:0] & mask;

  // byte order into the shifter
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bits[i] = cfg.reflect_input ? data_byte[7-i] : data_byte[i];
    end
  end

  // preset at message start, then eight msb-first shift steps
  always_comb begin
    logic top;
    crc = in_message ? (crc_in & mask) : (cfg.initial_value[REG_W-1:0] & mask);
    for (int i = 0; i < 8; i++) begin
      top = |(crc & topsel);
      crc = (crc << 1) & mask;
      if (bits[7-i] ^ top) begin
        crc = crc ^ poly;
      end
    end
  end

  assign crc_nxt = crc;

  // output reflection over the configured width
  always_comb begin
    for (int i = 0; i < REG_W; i++) begin
      rev[i] = crc[REG_W-1-i];
    end
  end

  assign fin = ((cfg.reflect_output ? (rev >> (RegWc - w)) : crc) ^
                cfg.final_xor[REG_W-1:0]) & mask;
  assign crc_value = pce_pkg::WordW'(fin);

endmodule

### hdl/parametric_crc_engine.sv
// path: an accepted byte waits in the input register and is folded into the running
//   remainder as it moves on; a last byte also loads the crc word into the output register
// throughput: one byte per cycle unless a last byte waits on a full output register that
//   is not read; the eight-step shift/xor fold updates the running remainder combinationally
// reset: synchronous active-low rst_n loads the crc-32 configuration and empties
//   the pipeline; the next byte starts a new message
module parametric_crc_engine #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pce_in_if.sink    in_chan,
  pce_out_if.source out_chan,
  pce_cfg_if.sink   cfg_chan
);

  localparam int unsigned RegW = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

  pce_pkg::cfg_t             cfg;
  logic                      s1_valid_r;
  logic [7:0]                s1_data_r;
  logic                      s1_last_r;
  logic [RegW-1:0]           crc_r;
  logic                      in_msg_r;
  logic                      out_valid_r;
  logic [pce_pkg::WordW-1:0] out_crc_r;
  logic [RegW-1:0]           crc_nxt;
  logic [pce_pkg::WordW-1:0] res_value;
  logic                      adv;

  // configuration bank
  pce_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // byte fold and finish
  pce_fold #(
    .MAX_WIDTH (MAX_WIDTH),
    .REG_W     (RegW)
  ) u_fold (
    .cfg        (cfg),
    .in_message (in_msg_r),
    .crc_in     (crc_r),
    .data_byte  (s1_data_r),
    .crc_nxt    (crc_nxt),
    .crc_value  (res_value)
  );

  // a held byte moves on unless it is a last byte facing a full output register that is not read
  assign adv           = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_data_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // running remainder and message flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else if (adv) begin
      in_msg_r <= !s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crc_r <= crc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_crc_r <= res_value;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.crc_value = out_crc_r;

`ifndef SYNTHESIS
  // a result only appears after a last byte was folded
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_last_r))
    else $error("result word without a last byte");

  // folding a last byte closes the message
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> !in_msg_r)
    else $error("message still open after last byte");

  // input stalls only behind a blocked result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule
